/* rtl/core/bdqs_pkg.sv */
// Shared types and codes for the bounded deque with search.
// No dependencies; used by bdqs_cell and bounded_deque_with_search.
package bdqs_pkg;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_SEARCH_EQ  = 3'd4;
    localparam logic [2:0] ACT_FIND_GT    = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [4:0] POS_NONE = 5'h1F;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_R,
        CELL_SHIFT_L,
        CELL_LOAD,
        CELL_CMP_EQ,
        CELL_CMP_GT,
        CELL_SCAN
    } t_cell_op;

endpackage

/* rtl/core/bdqs_cell.sv */
// One storage cell of the deque chain: holds a value and a match flag.
// Depends on bdqs_pkg for the cell operation codes.
module bdqs_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  bdqs_pkg::t_cell_op    i_op,
    input  logic                  i_we,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic                  i_right_match,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_match
);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;
    logic                  r_match;
    logic                  n_match;

    always_comb begin
        n_value = r_value;
        n_match = r_match;
        unique case (i_op)
            bdqs_pkg::CELL_HOLD: begin
            end
            bdqs_pkg::CELL_SHIFT_R: n_value = i_left_value;
            bdqs_pkg::CELL_SHIFT_L: n_value = i_right_value;
            bdqs_pkg::CELL_LOAD: begin
                if (i_we) begin
                    n_value = i_key;
                end
            end
            bdqs_pkg::CELL_CMP_EQ: n_match = (r_value == i_key);
            bdqs_pkg::CELL_CMP_GT: n_match = ($signed(r_value) > $signed(i_key));
            bdqs_pkg::CELL_SCAN:   n_match = i_right_match;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

/* rtl/core/bounded_deque_with_search.sv */
// Top level of the bounded deque with search: request/result streams and control.
// Depends on bdqs_pkg and a chain of bdqs_cell instances.
//
// Usage:
//   Requests enter on the s-side stream (i_s_tvalid/o_s_tready/i_s_tdata), one
//   result per request leaves on the m-side stream (o_m_tvalid/i_m_tready/o_m_tdata).
//   Entries live in a row of cells, front at cell 0; a push at the front shifts
//   the row right, a pop at the front shifts it left, a push at the back writes
//   the cell at the fill count, a pop at the back drops the fill count.
//   Push and pop requests do not scan: the result is registered at the accepting
//   edge and a new request may follow in the next cycle if the result is being drained.
//   Search and find-greater compare in every cell at acceptance, then shift the
//   match flags toward cell 0 one cell per cycle until a flag reaches cell 0 or
//   the scan index reaches the fill count; the result is then registered, and no
//   new request is taken meanwhile.
//   A request is taken whenever the block is not scanning and the result
//   register is empty or being drained; a stalled result holds, and a finished
//   scan waits in place until the result register frees.
//   Reset empties the queue and drops any pending result.
module bounded_deque_with_search #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [2:0] action, [34:3] value, [39:35] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [1:0] status, [2] hit, [7:3] position,
                                     // [12:8] count, [15:13] zero
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_scan_idx;
    logic [CNT_W-1:0] n_scan_idx;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic             r_hit;
    logic             n_hit;
    logic [4:0]       r_pos;
    logic [4:0]       n_pos;
    logic [4:0]       r_cnt_out;
    logic [4:0]       n_cnt_out;

    logic [2:0]            in_action;
    logic [31:0]           in_value;
    logic [VALUE_BITS+31:0] key_ext;
    logic [VALUE_BITS-1:0] key;
    logic                  accept;
    logic                  out_free;
    logic                  full;
    logic                  empty;
    logic                  scan_end;
    logic                  scan_hit;
    logic                  scan_done;
    logic [CNT_W+4:0]      count_ext;
    logic [CNT_W+4:0]      next_count_ext;
    logic [CNT_W+4:0]      idx_ext;
    bdqs_pkg::t_cell_op    cell_op;

    logic [VALUE_BITS-1:0] w_value [DEPTH];
    logic                  w_match [DEPTH];

    assign in_action = i_s_tdata[2:0];
    assign in_value  = i_s_tdata[34:3];
    assign key_ext   = {{VALUE_BITS{in_value[31]}}, in_value};
    assign key       = key_ext[VALUE_BITS-1:0];

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    assign scan_end  = (r_scan_idx == r_count);
    assign scan_hit  = !scan_end && w_match[0];
    assign scan_done = scan_end || w_match[0];

    assign count_ext      = {5'b0, r_count};
    assign next_count_ext = {5'b0, n_count};
    assign idx_ext        = {5'b0, r_scan_idx};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan_idx  = r_scan_idx;
        n_out_valid = r_out_valid && !i_m_tready;
        n_status    = r_status;
        n_hit       = r_hit;
        n_pos       = r_pos;
        n_cnt_out   = r_cnt_out;
        cell_op     = bdqs_pkg::CELL_HOLD;
        if (r_state == ST_SCAN) begin
            if (!scan_done) begin
                cell_op    = bdqs_pkg::CELL_SCAN;
                n_scan_idx = r_scan_idx + CNT_W'(1);
            end else if (out_free) begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_status    = bdqs_pkg::STATUS_OK;
                n_hit       = scan_hit;
                n_pos       = scan_hit ? idx_ext[4:0] : bdqs_pkg::POS_NONE;
                n_cnt_out   = count_ext[4:0];
            end
        end else if (accept) begin
            n_status = bdqs_pkg::STATUS_OK;
            n_hit    = 1'b0;
            n_pos    = bdqs_pkg::POS_NONE;
            unique case (in_action)
                bdqs_pkg::ACT_PUSH_FRONT: begin
                    if (full) begin
                        n_status = bdqs_pkg::STATUS_FULL;
                    end else begin
                        cell_op = bdqs_pkg::CELL_SHIFT_R;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                bdqs_pkg::ACT_PUSH_BACK: begin
                    if (full) begin
                        n_status = bdqs_pkg::STATUS_FULL;
                    end else begin
                        cell_op = bdqs_pkg::CELL_LOAD;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                bdqs_pkg::ACT_POP_FRONT: begin
                    if (empty) begin
                        n_status = bdqs_pkg::STATUS_EMPTY;
                    end else begin
                        cell_op = bdqs_pkg::CELL_SHIFT_L;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                bdqs_pkg::ACT_POP_BACK: begin
                    if (empty) begin
                        n_status = bdqs_pkg::STATUS_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                bdqs_pkg::ACT_SEARCH_EQ: cell_op = bdqs_pkg::CELL_CMP_EQ;
                bdqs_pkg::ACT_FIND_GT:   cell_op = bdqs_pkg::CELL_CMP_GT;
                default: begin
                end
            endcase
            if (in_action == bdqs_pkg::ACT_SEARCH_EQ || in_action == bdqs_pkg::ACT_FIND_GT) begin
                n_state    = ST_SCAN;
                n_scan_idx = '0;
            end else begin
                n_out_valid = 1'b1;
                n_cnt_out   = next_count_ext[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_idx  <= n_scan_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_hit     <= n_hit;
        r_pos     <= n_pos;
        r_cnt_out <= n_cnt_out;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VALUE_BITS-1:0] left_value;
            logic [VALUE_BITS-1:0] right_value;
            logic                  right_match;

            if (gi == 0) begin : g_first
                assign left_value = key;
            end else begin : g_mid_l
                assign left_value = w_value[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_value = w_value[gi];
                assign right_match = 1'b0;
            end else begin : g_mid_r
                assign right_value = w_value[gi+1];
                assign right_match = w_match[gi+1];
            end

            bdqs_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_op          (cell_op),
                .i_we          (r_count == CNT_W'(gi)),
                .i_key         (key),
                .i_left_value  (left_value),
                .i_right_value (right_value),
                .i_right_match (right_match),
                .o_value       (w_value[gi]),
                .o_match       (w_match[gi])
            );
        end
    endgenerate

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_cnt_out, r_pos, r_hit, r_status};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan_idx <= r_count))
        else $error("scan index beyond fill count");

    a_scan_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> (r_count == $past(r_count)))
        else $error("fill count changed during scan");

    a_push_back_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_action == bdqs_pkg::ACT_PUSH_BACK && !full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push at back did not grow the queue");
`endif

endmodule

/* sim/deque_result_checker.sv */
// Watches the request and result streams of bounded_deque_with_search, keeps its own
// copy of the queue contents, predicts each result and compares it field by field.
// Depends on bdqs_pkg for action and status codes.
module deque_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // [2:0] action, [34:3] value, [39:35] zero
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [1:0] status, [2] hit, [7:3] position,
                                     // [12:8] count, [15:13] zero
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_hits,
    output int          o_full_rejects,
    output int          o_empty_rejects,
    output int          o_peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
        logic [1:0]  status;
        logic        hit;
        logic [4:0]  position;
        logic [4:0]  count;
    } t_deque_reply;

    logic signed [31:0] held_values[$];
    t_deque_reply       awaited_results[$];

    function automatic void note_failure();
        o_fail_count++;
    endfunction

    function automatic void check_field(string name, int want, int got, t_deque_reply req);
        if (want != got) begin
            note_failure();
            $display("%0t: %s mismatch (action %0d, value %0d): expected %0d, got %0d",
                     $time, name, req.action, $signed(req.value), want, got);
        end
    endfunction

    function automatic t_deque_reply apply_request(logic [2:0] act, logic signed [31:0] key);
        t_deque_reply r;
        r.action   = act;
        r.value    = key;
        r.status   = bdqs_pkg::STATUS_OK;
        r.hit      = 1'b0;
        r.position = bdqs_pkg::POS_NONE;
        case (act)
            bdqs_pkg::ACT_PUSH_FRONT, bdqs_pkg::ACT_PUSH_BACK: begin
                if (held_values.size() >= QUEUE_DEPTH) begin
                    r.status = bdqs_pkg::STATUS_FULL;
                    o_full_rejects++;
                end else if (act == bdqs_pkg::ACT_PUSH_FRONT) begin
                    held_values.push_front(key);
                end else begin
                    held_values.push_back(key);
                end
            end
            bdqs_pkg::ACT_POP_FRONT, bdqs_pkg::ACT_POP_BACK: begin
                if (held_values.size() == 0) begin
                    r.status = bdqs_pkg::STATUS_EMPTY;
                    o_empty_rejects++;
                end else if (act == bdqs_pkg::ACT_POP_FRONT) begin
                    void'(held_values.pop_front());
                end else begin
                    void'(held_values.pop_back());
                end
            end
            bdqs_pkg::ACT_SEARCH_EQ, bdqs_pkg::ACT_FIND_GT: begin
                for (int i = 0; i < held_values.size() && !r.hit; i++) begin
                    if ((act == bdqs_pkg::ACT_SEARCH_EQ) ? (held_values[i] == key)
                                                         : (held_values[i] > key)) begin
                        r.hit      = 1'b1;
                        r.position = i[4:0];
                    end
                end
                if (r.hit)
                    o_hits++;
            end
            default: ;
        endcase
        r.count = 5'(held_values.size());
        if (held_values.size() > o_peak_fill)
            o_peak_fill = held_values.size();
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_deque_reply want;
        if (!i_rst_n) begin
            held_values.delete();
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    note_failure();
                    $display("%0t: result with no request waiting: expected none, got %h",
                             $time, i_m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    o_checked++;
                    check_field("status", want.status, i_m_tdata[1:0], want);
                    check_field("hit", want.hit, i_m_tdata[2], want);
                    check_field("position", $signed(want.position),
                                $signed(i_m_tdata[7:3]), want);
                    check_field("count", want.count, i_m_tdata[12:8], want);
                    check_field("padding", 0, i_m_tdata[15:13], want);
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(apply_request(i_s_tdata[2:0], i_s_tdata[34:3]));
        end
        o_pending = awaited_results.size();
    end

endmodule

/* sim/tb.sv */
// Stimulus and verdict for bounded_deque_with_search: directed corner requests, then
// random phases with idling and back-pressure. Depends on bdqs_pkg and deque_result_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int PHASE_LEN       = 50;
    localparam int PRESSURE_PHASE  = 2;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 24;
    localparam int SETTLE_LIMIT    = 4000;
    localparam int TIMEOUT_NS      = 5_000_000;

    typedef enum {MOOD_FILL, MOOD_DRAIN, MOOD_SEARCH, MOOD_MIXED} t_mood;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [2:0] action, [34:3] value, [39:35] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [1:0] status, [2] hit, [7:3] position, [12:8] count

    int fail_count, pending, checked, hits, full_rejects, empty_rejects, peak_fill;

    bit          tx_idle;
    bit          rx_idle;
    bit          hold_off_wanted;
    int          requests_sent;
    logic [31:0] recent_values[8];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bounded_deque_with_search DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    deque_result_checker result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_hits          (hits),
        .o_full_rejects  (full_rejects),
        .o_empty_rejects (empty_rejects),
        .o_peak_fill     (peak_fill)
    );

    function automatic logic [31:0] draw_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return recent_values[$urandom_range(0, 7)];
        if (r < 45)
            return $urandom_range(0, 8) - 4;
        if (r < 55) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_action(t_mood mood);
        int r, push_end, pop_end;
        r = $urandom_range(0, 99);
        case (mood)
            MOOD_FILL:   begin push_end = 70; pop_end = 82; end
            MOOD_DRAIN:  begin push_end = 25; pop_end = 75; end
            MOOD_SEARCH: begin push_end = 25; pop_end = 45; end
            default:     begin push_end = 40; pop_end = 70; end
        endcase
        if (r < 3)
            return (r == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
        if (r < push_end)
            return $urandom_range(0, 1) ? bdqs_pkg::ACT_PUSH_FRONT : bdqs_pkg::ACT_PUSH_BACK;
        if (r < pop_end)
            return $urandom_range(0, 1) ? bdqs_pkg::ACT_POP_FRONT : bdqs_pkg::ACT_POP_BACK;
        return $urandom_range(0, 1) ? bdqs_pkg::ACT_SEARCH_EQ : bdqs_pkg::ACT_FIND_GT;
    endfunction

    // entered and left just after a falling edge
    task automatic send_request(input logic [2:0] act, input logic [31:0] val);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, act};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        requests_sent++;
        if (act == bdqs_pkg::ACT_PUSH_FRONT || act == bdqs_pkg::ACT_PUSH_BACK)
            recent_values[$urandom_range(0, 7)] = val;
        @(negedge clk);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        while (pending != 0 && waited < SETTLE_LIMIT) begin
            @(negedge clk);
            waited++;
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (hold_off_wanted) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_wanted = 1'b0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        int    phase_idx;
        t_mood mood;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        tx_idle         = 1'b0;
        rx_idle         = 1'b0;
        hold_off_wanted = 1'b0;
        requests_sent   = 0;
        recent_values   = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                            32'h1, 32'h2, 32'h8000_0001, 32'h7FFF_FFFE};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(bdqs_pkg::ACT_POP_FRONT, 32'h0);
        send_request(bdqs_pkg::ACT_POP_BACK, 32'h0);
        send_request(bdqs_pkg::ACT_SEARCH_EQ, 32'h0);
        send_request(bdqs_pkg::ACT_FIND_GT, 32'h8000_0000);
        send_request(ACT_SPARE_LO, 32'hFFFF_FFFF);
        send_request(ACT_SPARE_HI, 32'h0);
        send_request(bdqs_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(bdqs_pkg::ACT_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(bdqs_pkg::ACT_PUSH_FRONT, 32'h0);
        send_request(bdqs_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(bdqs_pkg::ACT_SEARCH_EQ, 32'h7FFF_FFFF);
        send_request(bdqs_pkg::ACT_SEARCH_EQ, 32'hFFFF_FFFF);
        send_request(bdqs_pkg::ACT_SEARCH_EQ, 32'h5);
        send_request(bdqs_pkg::ACT_FIND_GT, 32'h8000_0000);
        send_request(bdqs_pkg::ACT_FIND_GT, 32'h7FFF_FFFF);
        send_request(bdqs_pkg::ACT_FIND_GT, 32'hFFFF_FFFF);
        send_request(bdqs_pkg::ACT_FIND_GT, 32'h0);
        send_request(bdqs_pkg::ACT_POP_FRONT, 32'h0);
        send_request(bdqs_pkg::ACT_POP_BACK, 32'h0);
        send_request(bdqs_pkg::ACT_POP_BACK, 32'h0);
        send_request(bdqs_pkg::ACT_POP_FRONT, 32'h0);
        send_request(bdqs_pkg::ACT_POP_FRONT, 32'h0);

        for (phase_idx = 0; requests_sent < RANDOM_REQUESTS; phase_idx++) begin
            mood    = (phase_idx == 0) ? MOOD_FILL : t_mood'($urandom_range(0, 3));
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            if (phase_idx == PRESSURE_PHASE) begin
                mood            = MOOD_FILL;
                tx_idle         = 1'b0;
                hold_off_wanted = 1'b1;
            end
            repeat (PHASE_LEN) send_request(pick_action(mood), draw_value());
            if (phase_idx % 5 == 4)
                settle();
        end
        s_tvalid <= 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        $display("Run covered %0d requests and %0d checked results: %0d search hits,",
                 requests_sent, checked, hits);
        $display("%0d pushes refused as full, %0d pops refused as empty, peak fill %0d.",
                 full_rejects, empty_rejects, peak_fill);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
